// ----- sv/track_length_dose_estimator_unit_defines.svh -----
// Assertion macros shared by the checker of the dose estimator.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef TRACK_LENGTH_DOSE_ESTIMATOR_UNIT_DEFINES_SVH
`define TRACK_LENGTH_DOSE_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TLDE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlde check failed");

// next-cycle implication
`define TLDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlde check failed");

`endif

// ----- sv/tlde_pkg.sv -----
// Types, constants and constant functions of the dose estimator.
// Used by tlde_div, the top level, the checker and the testbench; depends on nothing.
package tlde_pkg;

    localparam int MAX_ELEMENTS       = 128;
    localparam int POINTS_PER_ELEMENT = 64;

    localparam int ELEM_W      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W       = $clog2(POINTS_PER_ELEMENT + 1);
    localparam int PT_W        = $clog2(POINTS_PER_ELEMENT);
    localparam int TABLE_DEPTH = MAX_ELEMENTS * POINTS_PER_ELEMENT;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int LG_W    = 21;   // Q5.16 log2
    localparam int SUM_W   = 48;
    localparam int VOL_W   = 48;
    localparam int DIV_W   = 160;
    localparam int QUO_W   = 64;
    localparam int DSTEP_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TERM = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  atomic_number;
        logic [5:0]  point_index;
        logic        point_last;
        logic [31:0] point_energy;
        logic [31:0] point_coeff;
        logic [15:0] weight_fraction;
        logic        last_element;
        logic [31:0] kinetic_energy;
        logic [31:0] step_length;
        logic [31:0] track_weight;
        logic [47:0] cell_volume;
    } tlde_item_t;

    typedef struct packed {
        logic [63:0] deposit;
        logic        counted;
    } tlde_result_t;

    typedef struct packed {
        logic               start;
        logic [DSTEP_W-1:0] steps;
    } tlde_div_ctrl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } tlde_div_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CNT,
        S_FIRST,
        S_LASTPT,
        S_SEARCH,
        S_PROBE,
        S_LG_NORM,
        S_LG_SQ,
        S_T,
        S_TDIV,
        S_Y,
        S_EXP,
        S_EXP_SH,
        S_LIN1,
        S_LIN2,
        S_WEIGHT,
        S_MUL,
        S_SDIV,
        S_SDIV_WAIT,
        S_OUT
    } tlde_state_t;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        rem  = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q1.31 root 2^(2^(k-16)) for fraction bit k
    function automatic logic [31:0] exp_c(int k);
        logic [63:0] c;
        c = isqrt64(64'h8000_0000_0000_0000);
        for (int j = 15; j > k; j--) begin
            c = isqrt64(c << 31);
        end
        return c[31:0];
    endfunction

    localparam logic [31:0] EXP_C [16] = '{
        exp_c(0),  exp_c(1),  exp_c(2),  exp_c(3),
        exp_c(4),  exp_c(5),  exp_c(6),  exp_c(7),
        exp_c(8),  exp_c(9),  exp_c(10), exp_c(11),
        exp_c(12), exp_c(13), exp_c(14), exp_c(15)
    };

endpackage

// ----- sv/tlde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tlde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tlde_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tlde_pkg.
module tlde_div import tlde_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  tlde_div_ctrl_t     ctrl,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [VOL_W-1:0]   divisor,
    output tlde_div_stat_t     stat,
    output logic [QUO_W-1:0]   quotient
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DSTEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [VOL_W-1:0]   rem_reg, rem_next;
    logic [VOL_W-1:0]   dvsr_reg, dvsr_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               sat_reg, sat_next;
    logic [VOL_W:0]     trial;
    logic [VOL_W:0]     diff;
    logic               ge;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign ge    = (trial >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctrl.steps;
            dvd_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = '0;
            sat_next  = 1'b0;
        end else if (busy_reg)
        begin
            rem_next = ge ? diff[VOL_W-1:0] : trial[VOL_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], ge};
            // a quotient bit above the 64-bit result saturates
            if (ge && (cnt_reg > DSTEP_W'(QUO_W)))
            begin
                sat_next = 1'b1;
            end
            cnt_next = cnt_reg - DSTEP_W'(1);
            if (cnt_reg == DSTEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign quotient  = quo_reg;

endmodule

// ----- sv/track_length_dose_estimator_unit.sv -----
// Track-length dose estimator top level; uses tlde_pkg, tlde_ram and tlde_div.
// A load item is taken while idle and leaves the block idle. A term item keeps it busy
// through the count read, search probes, 3 or 5 log2s, the interpolation divide and exp2.
// Last element with nonzero step adds a limb-serial multiply, a divide and an output step,
// longer while the result register is stalled; one item at a time.
// Reset clears point counts and the running sum; tables are undefined until loaded.
module track_length_dose_estimator_unit import tlde_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  tlde_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output tlde_result_t result
);

    tlde_state_t state_reg, state_next;

    logic [6:0]        z_reg, z_next;
    logic [31:0]       ke_reg, ke_next;
    logic [31:0]       step_reg, step_next;
    logic [31:0]       tw_reg, tw_next;
    logic [47:0]       vol_reg, vol_next;
    logic [15:0]       wf_reg, wf_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [PT_W-1:0]   lo_reg, lo_next;
    logic [PT_W-1:0]   hi_reg, hi_next;
    logic [PT_W-1:0]   mid_reg, mid_next;
    logic [31:0]       e1_reg, e1_next;
    logic [31:0]       e2_reg, e2_next;
    logic [31:0]       d1_reg, d1_next;
    logic [31:0]       d2_reg, d2_next;
    logic [2:0]        sel_reg, sel_next;
    logic [31:0]       lgm_reg, lgm_next;
    logic [LG_W-1:0]   lgr_reg, lgr_next;
    logic [3:0]        iter_reg, iter_next;
    logic [LG_W-1:0]   lg1_reg, lg1_next;
    logic [LG_W-1:0]   lg2_reg, lg2_next;
    logic [LG_W-1:0]   lgx_reg, lgx_next;
    logic [LG_W-1:0]   lga_reg, lga_next;
    logic [LG_W-1:0]   lgb_reg, lgb_next;
    logic [16:0]       t_reg, t_next;
    logic [31:0]       expm_reg, expm_next;
    logic [4:0]        ip_reg, ip_next;
    logic [15:0]       f_reg, f_next;
    logic [48:0]       acc_reg, acc_next;
    logic [31:0]       term_reg, term_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIV_W-1:0]  w_reg, w_next;
    logic [31:0]       carry_reg, carry_next;
    logic [2:0]        limb_reg, limb_next;
    logic [1:0]        pass_reg, pass_next;
    tlde_result_t      res_reg, res_next;
    logic              result_valid_reg, result_valid_next;
    tlde_result_t      result_reg, result_next;
    logic [MAX_ELEMENTS-1:0] cnt_valid_reg, cnt_valid_next;

    // shared multiplier
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;

    // tables
    logic              accept;
    logic              load_ok;
    logic              tab_we;
    logic [ADDR_W-1:0] tab_waddr, tab_raddr, base;
    logic [ADDR_W-1:0] rd_idx;
    logic [63:0]       tab_rdata;
    logic [ELEM_W-1:0] cnt_raddr, cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic [31:0]       rd_energy, rd_coeff;

    // divider
    tlde_div_ctrl_t    div_ctrl;
    tlde_div_stat_t    div_stat;
    logic [DIV_W-1:0]  div_dvd;
    logic [VOL_W-1:0]  div_dvsr;
    logic [QUO_W-1:0]  div_quo;

    // datapath temporaries
    logic              z_ok;
    logic [CNT_W-1:0]  n_eff;
    logic [PT_W:0]     mid_sum;
    logic [PT_W-1:0]   mid_c;
    logic [31:0]       lg_op;
    logic [4:0]        lg_p;
    logic [32:0]       sq;
    logic              lg_done;
    logic [LG_W-1:0]   lg_val;
    logic [LG_W:0]     den, num, numc;
    logic [LG_W:0]     ddiff, dabs;
    logic [39:0]       ybase, yv, yr;
    logic [63:0]       shv;
    logic [47:0]       wsum;
    logic [31:0]       wtd;
    logic [SUM_W:0]    snew;
    logic [SUM_W-1:0]  ssat;
    logic [31:0]       mfac;
    logic [63:0]       mlimb;
    logic [48:0]       lin;

    function automatic logic [4:0] msb_pos(logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    assign load_ok   = (32'(item.atomic_number) < 32'(MAX_ELEMENTS)) &&
                       (32'(item.point_index) < 32'(POINTS_PER_ELEMENT));
    assign tab_we    = accept && (item.opcode == OP_LOAD) && load_ok;
    assign tab_waddr = ADDR_W'(item.atomic_number) * ADDR_W'(POINTS_PER_ELEMENT) +
                       ADDR_W'(item.point_index);
    assign cnt_waddr = ELEM_W'(item.atomic_number);
    assign cnt_wdata = CNT_W'(item.point_index) + CNT_W'(1);
    assign cnt_raddr = ELEM_W'(item.atomic_number);

    assign base      = ADDR_W'(z_reg) * ADDR_W'(POINTS_PER_ELEMENT);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c     = mid_sum[PT_W:1];
    assign rd_energy = tab_rdata[63:32];
    assign rd_coeff  = tab_rdata[31:0];

    always_comb
    begin
        case (state_reg)
            S_FIRST:  rd_idx = ADDR_W'(n_reg) - ADDR_W'(1);
            S_SEARCH: rd_idx = ADDR_W'(mid_c);
            default:  rd_idx = '0;
        endcase
    end
    assign tab_raddr = base + rd_idx;

    tlde_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata ({item.point_energy, item.point_coeff}),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    tlde_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_count (
        .clk   (clk),
        .we    (tab_we && item.point_last),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    tlde_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dvd),
        .divisor  (div_dvsr),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign mul_p = mul_a * mul_b;

    // combinational datapath pieces
    always_comb
    begin
        z_ok  = (32'(z_reg) < 32'(MAX_ELEMENTS));
        n_eff = cnt_valid_reg[ELEM_W'(z_reg)] ? cnt_rdata : '0;

        case (sel_reg)
            3'd0:    lg_op = e1_reg;
            3'd1:    lg_op = e2_reg;
            3'd2:    lg_op = ke_reg;
            3'd3:    lg_op = d1_reg;
            default: lg_op = d2_reg;
        endcase
        lg_p = msb_pos(lg_op);
        sq   = mul_p[63:31];

        den  = {1'b0, lg2_reg} - {1'b0, lg1_reg};
        num  = {1'b0, lgx_reg} - {1'b0, lg1_reg};
        if (num[LG_W])
        begin
            numc = '0;
        end else if ($signed(num) > $signed(den))
        begin
            numc = den;
        end else
        begin
            numc = num;
        end

        ddiff = {1'b0, lgb_reg} - {1'b0, lga_reg};
        dabs  = ddiff[LG_W] ? (~ddiff + (LG_W+1)'(1)) : ddiff;
        ybase = {3'b0, lga_reg, 16'b0};
        yv    = ddiff[LG_W] ? (ybase - 40'(mul_p[37:0])) : (ybase + 40'(mul_p[37:0]));
        yr    = (yv[39] ? 40'd0 : yv) + 40'd32768;

        shv   = {32'b0, expm_reg} << ip_reg;

        wsum  = mul_p[47:0] + 48'd32768;
        wtd   = wsum[47:16];
        snew  = {1'b0, sum_reg} + (SUM_W+1)'(wtd);
        ssat  = snew[SUM_W] ? '1 : snew[SUM_W-1:0];

        case (pass_reg)
            2'd0:    mfac = ke_reg;
            2'd1:    mfac = step_reg;
            default: mfac = tw_reg;
        endcase
        mlimb = mul_p + {32'b0, carry_reg};

        lin   = acc_reg + 49'(mul_p[48:0]) + 49'd32768;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        z_next            = z_reg;
        ke_next           = ke_reg;
        step_next         = step_reg;
        tw_next           = tw_reg;
        vol_next          = vol_reg;
        wf_next           = wf_reg;
        last_next         = last_reg;
        n_next            = n_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        e1_next           = e1_reg;
        e2_next           = e2_reg;
        d1_next           = d1_reg;
        d2_next           = d2_reg;
        sel_next          = sel_reg;
        lgm_next          = lgm_reg;
        lgr_next          = lgr_reg;
        iter_next         = iter_reg;
        lg1_next          = lg1_reg;
        lg2_next          = lg2_reg;
        lgx_next          = lgx_reg;
        lga_next          = lga_reg;
        lgb_next          = lgb_reg;
        t_next            = t_reg;
        expm_next         = expm_reg;
        ip_next           = ip_reg;
        f_next            = f_reg;
        acc_next          = acc_reg;
        term_next         = term_reg;
        sum_next          = sum_reg;
        w_next            = w_reg;
        carry_next        = carry_reg;
        limb_next         = limb_reg;
        pass_next         = pass_reg;
        res_next          = res_reg;
        cnt_valid_next    = cnt_valid_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        mul_a             = '0;
        mul_b             = '0;
        div_ctrl.start    = 1'b0;
        div_ctrl.steps    = '0;
        div_dvd           = '0;
        div_dvsr          = '0;
        lg_done           = 1'b0;
        lg_val            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    z_next    = item.atomic_number;
                    ke_next   = item.kinetic_energy;
                    step_next = item.step_length;
                    tw_next   = item.track_weight;
                    vol_next  = item.cell_volume;
                    wf_next   = item.weight_fraction;
                    last_next = item.last_element;
                    if (item.opcode == OP_TERM)
                    begin
                        state_next = S_CNT;
                    end else if (load_ok && item.point_last)
                    begin
                        cnt_valid_next[ELEM_W'(item.atomic_number)] = 1'b1;
                    end
                end
            end

            S_CNT:
            begin
                n_next = n_eff;
                if (!z_ok || (n_eff == '0) || (n_eff > CNT_W'(POINTS_PER_ELEMENT)))
                begin
                    term_next  = '0;
                    state_next = S_WEIGHT;
                end else
                begin
                    state_next = S_FIRST;
                end
            end

            S_FIRST:
            begin
                if (ke_reg < rd_energy)
                begin
                    term_next  = '0;
                    state_next = S_WEIGHT;
                end else
                begin
                    e1_next    = rd_energy;
                    d1_next    = rd_coeff;
                    state_next = S_LASTPT;
                end
            end

            S_LASTPT:
            begin
                if (ke_reg >= rd_energy)
                begin
                    term_next  = rd_coeff;
                    state_next = S_WEIGHT;
                end else
                begin
                    e2_next    = rd_energy;
                    d2_next    = rd_coeff;
                    lo_next    = '0;
                    hi_next    = PT_W'(n_reg - CNT_W'(1));
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if ((hi_reg - lo_reg) > PT_W'(1))
                begin
                    mid_next   = mid_c;
                    state_next = S_PROBE;
                end else
                begin
                    sel_next   = 3'd0;
                    state_next = S_LG_NORM;
                end
            end

            S_PROBE:
            begin
                if (rd_energy <= ke_reg)
                begin
                    lo_next = mid_reg;
                    e1_next = rd_energy;
                    d1_next = rd_coeff;
                end else
                begin
                    hi_next = mid_reg;
                    e2_next = rd_energy;
                    d2_next = rd_coeff;
                end
                state_next = S_SEARCH;
            end

            S_LG_NORM:
            begin
                if (lg_op == '0)
                begin
                    lg_done = 1'b1;
                    lg_val  = '0;
                end else
                begin
                    lgm_next   = lg_op << (5'd31 - lg_p);
                    lgr_next   = {lg_p, 16'b0};
                    iter_next  = 4'd15;
                    state_next = S_LG_SQ;
                end
            end

            S_LG_SQ:
            begin
                // mantissa squared in Q1.31; a carry past 2.0 gives the next bit
                mul_a = lgm_reg;
                mul_b = lgm_reg;
                if (sq[32])
                begin
                    lgm_next = sq[32:1];
                    lgr_next = lgr_reg | (LG_W'(1) << iter_reg);
                end else
                begin
                    lgm_next = sq[31:0];
                    lgr_next = lgr_reg;
                end
                iter_next = iter_reg - 4'd1;
                if (iter_reg == 4'd0)
                begin
                    lg_done = 1'b1;
                    lg_val  = lgr_next;
                end
            end

            S_T:
            begin
                if (den[LG_W] || (den == '0))
                begin
                    t_next = '0;
                    if ((d1_reg != '0) && (d2_reg != '0))
                    begin
                        sel_next   = 3'd3;
                        state_next = S_LG_NORM;
                    end else
                    begin
                        state_next = S_LIN1;
                    end
                end else
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = DSTEP_W'(LG_W + 17);
                    div_dvd        = {1'b0, numc[LG_W-1:0], 16'b0,
                                      (DIV_W - LG_W - 17)'(0)};
                    div_dvsr       = VOL_W'(den);
                    state_next     = S_TDIV;
                end
            end

            S_TDIV:
            begin
                if (div_stat.done)
                begin
                    t_next = div_quo[16:0];
                    if ((d1_reg != '0) && (d2_reg != '0))
                    begin
                        sel_next   = 3'd3;
                        state_next = S_LG_NORM;
                    end else
                    begin
                        state_next = S_LIN1;
                    end
                end
            end

            S_Y:
            begin
                mul_a      = 32'(t_reg);
                mul_b      = 32'(dabs);
                f_next     = yr[31:16];
                ip_next    = yr[36:32];
                expm_next  = 32'h8000_0000;
                iter_next  = 4'd15;
                state_next = S_EXP;
            end

            S_EXP:
            begin
                mul_a = expm_reg;
                mul_b = EXP_C[iter_reg];
                if (f_reg[iter_reg])
                begin
                    expm_next = mul_p[62:31];
                end
                iter_next = iter_reg - 4'd1;
                if (iter_reg == 4'd0)
                begin
                    state_next = S_EXP_SH;
                end
            end

            S_EXP_SH:
            begin
                term_next  = shv[62:31];
                state_next = S_WEIGHT;
            end

            S_LIN1:
            begin
                mul_a      = d1_reg;
                mul_b      = 32'(17'h10000 - t_reg);
                acc_next   = 49'(mul_p[48:0]);
                state_next = S_LIN2;
            end

            S_LIN2:
            begin
                mul_a      = d2_reg;
                mul_b      = 32'(t_reg);
                term_next  = lin[47:16];
                state_next = S_WEIGHT;
            end

            S_WEIGHT:
            begin
                mul_a = term_reg;
                mul_b = {16'b0, wf_reg};
                if (last_reg)
                begin
                    sum_next = '0;
                    if (step_reg == '0)
                    begin
                        res_next.deposit = '0;
                        res_next.counted = 1'b0;
                        state_next       = S_OUT;
                    end else
                    begin
                        w_next     = DIV_W'(ssat);
                        carry_next = '0;
                        limb_next  = '0;
                        pass_next  = '0;
                        state_next = S_MUL;
                    end
                end else
                begin
                    sum_next   = ssat;
                    state_next = S_IDLE;
                end
            end

            S_MUL:
            begin
                // limbs rotate through the low word, one 32x32 product per cycle
                mul_a  = w_reg[31:0];
                mul_b  = mfac;
                w_next = {mlimb[31:0], w_reg[DIV_W-1:32]};
                if (limb_reg == 3'd4)
                begin
                    limb_next  = '0;
                    carry_next = '0;
                    if (pass_reg == 2'd2)
                    begin
                        state_next = S_SDIV;
                    end else
                    begin
                        pass_next = pass_reg + 2'd1;
                    end
                end else
                begin
                    limb_next  = limb_reg + 3'd1;
                    carry_next = mlimb[63:32];
                end
            end

            S_SDIV:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.steps = DSTEP_W'(DIV_W);
                div_dvd        = w_reg;
                div_dvsr       = (vol_reg == '0) ? VOL_W'(1) : vol_reg;
                state_next     = S_SDIV_WAIT;
            end

            S_SDIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    res_next.deposit = div_stat.sat ? '1 : div_quo;
                    res_next.counted = 1'b1;
                    state_next       = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_next       = res_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // store a finished log2, then pick the next operand or move on to S_T or S_Y
        if (lg_done)
        begin
            case (sel_reg)
                3'd0:    lg1_next = lg_val;
                3'd1:    lg2_next = lg_val;
                3'd2:    lgx_next = lg_val;
                3'd3:    lga_next = lg_val;
                default: lgb_next = lg_val;
            endcase
            if (sel_reg == 3'd2)
            begin
                state_next = S_T;
            end else if (sel_reg == 3'd4)
            begin
                state_next = S_Y;
            end else
            begin
                sel_next   = sel_reg + 3'd1;
                state_next = S_LG_NORM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sum_reg          <= '0;
            cnt_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            cnt_valid_reg    <= cnt_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg      <= z_next;
        ke_reg     <= ke_next;
        step_reg   <= step_next;
        tw_reg     <= tw_next;
        vol_reg    <= vol_next;
        wf_reg     <= wf_next;
        last_reg   <= last_next;
        n_reg      <= n_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        sel_reg    <= sel_next;
        lgm_reg    <= lgm_next;
        lgr_reg    <= lgr_next;
        iter_reg   <= iter_next;
        lg1_reg    <= lg1_next;
        lg2_reg    <= lg2_next;
        lgx_reg    <= lgx_next;
        lga_reg    <= lga_next;
        lgb_reg    <= lgb_next;
        t_reg      <= t_next;
        expm_reg   <= expm_next;
        ip_reg     <= ip_next;
        f_reg      <= f_next;
        acc_reg    <= acc_next;
        term_reg   <= term_next;
        w_reg      <= w_next;
        carry_reg  <= carry_next;
        limb_reg   <= limb_next;
        pass_reg   <= pass_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/tlde_checker.sv -----
// Port-level checks of the dose estimator, bound to the top level.
// Depends on tlde_pkg and track_length_dose_estimator_unit_defines.svh.
`include "track_length_dose_estimator_unit_defines.svh"

module tlde_checker import tlde_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input tlde_item_t   item,
    input logic         result_valid,
    input logic         result_stall,
    input tlde_result_t result
);

    // a stalled result holds
    `TLDE_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result))

    // an uncounted step scores nothing
    `TLDE_ASSERT_NOW(a_uncounted_zero, result_valid && !result.counted,
        result.deposit == 64'd0)

    // a term item keeps the block busy for the next cycle
    `TLDE_ASSERT_NEXT(a_term_busy, item_valid && !item_stall && (item.opcode == OP_TERM),
        item_stall)

    // a new result only comes out of a busy period
    `TLDE_ASSERT_NOW(a_result_from_work, $rose(result_valid), $past(item_stall))

endmodule

bind track_length_dose_estimator_unit tlde_checker u_checker (.*);

// ----- verif/track_length_dose_estimator_unit_tb.sv -----
// Testbench of track_length_dose_estimator_unit: loads element tables, scores steps
// and checks each deposit against a predictor of its own. Depends on tlde_pkg and the top level.
module track_length_dose_estimator_unit_tb;
    import tlde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS       = 128;
    localparam int NPTS        = 64;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 400;
    localparam int HOLDOFF_LEN = 800;
    localparam int ITEM_BITS   = $bits(tlde_item_t);
    localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    tlde_item_t   item;
    logic         result_valid;
    logic         result_stall;
    tlde_result_t result;

    track_length_dose_estimator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor state
    logic [31:0]    energy_rows [NROWS*NPTS];
    logic [31:0]    coeff_rows [NROWS*NPTS];
    int unsigned    row_points [NROWS];
    logic [NPTS-1:0] row_loaded [NROWS];
    logic [47:0]    running_sum;
    tlde_result_t   pending_deposits [$];

    int sender_idle_pct;
    int receiver_idle_pct;
    bit holdoff_armed = 1'b0;
    bit holdoff_done;
    int holdoff_cycles;
    int mismatches = 0;
    int items_sent;
    int loads_sent;
    int deposits_seen = 0;
    int saturated_seen = 0;
    int quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint log2_q16(logic [31:0] v);
        int p;
        logic [63:0] m;
        longint r;
        if (v == 0)
            return 0;
        p = 31;
        while (v[p] == 1'b0)
            p--;
        m = 64'(v) << (31 - p);
        r = longint'(p) << 16;
        for (int i = 15; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                r = r | (longint'(1) << i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pow2_q16(logic [63:0] y16);
        logic [63:0] ip;
        logic [63:0] m;
        logic [63:0] c;
        ip = (y16 >> 16) & 64'd31;
        m  = 64'h8000_0000;
        c  = int_sqrt(64'h8000_0000_0000_0000);
        for (int k = 15; k >= 0; k--)
        begin
            if (y16[k])
                m = (m * c) >> 31;
            c = int_sqrt(c << 31);
        end
        return 32'((m << ip) >> 31);
    endfunction

    function automatic logic [31:0] interp_coeff(int z, logic [31:0] x);
        int unsigned n, base, lo, hi, mid;
        logic [31:0] e1, e2, d1, d2;
        longint l1, den, num, t, a, b, y;
        n = row_points[z];
        if (n == 0)
            return 0;
        base = z * NPTS;
        if (x < energy_rows[base])
            return 0;
        if (x >= energy_rows[base+n-1])
            return coeff_rows[base+n-1];
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (energy_rows[base+mid] <= x)
                lo = mid;
            else
                hi = mid;
        end
        e1 = energy_rows[base+lo];
        e2 = energy_rows[base+hi];
        d1 = coeff_rows[base+lo];
        d2 = coeff_rows[base+hi];
        l1  = log2_q16(e1);
        den = log2_q16(e2) - l1;
        num = log2_q16(x) - l1;
        if (den <= 0)
            t = 0;
        else
        begin
            if (num < 0)
                num = 0;
            if (num > den)
                num = den;
            t = (num * 65536) / den;
        end
        if (d1 != 0 && d2 != 0)
        begin
            a = log2_q16(d1);
            b = log2_q16(d2);
            y = a * 65536 + t * (b - a);
            if (y < 0)
                y = 0;
            return pow2_q16((64'(y) + 64'd32768) >> 16);
        end
        return 32'((64'(d1) * 64'(65536 - t) + 64'(d2) * 64'(t) + 64'd32768) >> 16);
    endfunction

    function automatic logic [63:0] scored_deposit(logic [47:0] s, tlde_item_t it);
        logic [159:0] prod;
        logic [159:0] q;
        logic [47:0]  vol;
        vol  = (it.cell_volume == 0) ? 48'd1 : it.cell_volume;
        prod = 160'(s) * 160'(it.kinetic_energy);
        prod = prod * 160'(it.step_length);
        prod = prod * 160'(it.track_weight);
        q    = prod / 160'(vol);
        if (q[159:64] != 0)
            return '1;
        return q[63:0];
    endfunction

    task automatic apply_item(tlde_item_t it);
        int z, idx;
        logic [63:0] w;
        tlde_result_t r;
        z = int'(it.atomic_number);
        if (it.opcode == OP_LOAD)
        begin
            idx = int'(it.point_index);
            energy_rows[z*NPTS+idx] = it.point_energy;
            coeff_rows[z*NPTS+idx]  = it.point_coeff;
            row_loaded[z][idx] = 1'b1;
            if (it.point_last)
                row_points[z] = idx + 1;
            loads_sent++;
            return;
        end
        w = (64'(interp_coeff(z, it.kinetic_energy)) * 64'(it.weight_fraction) + 64'd32768) >> 16;
        if (64'(running_sum) + w > 64'(SUM_SAT))
            running_sum = SUM_SAT;
        else
            running_sum = running_sum + w[47:0];
        if (!it.last_element)
            return;
        if (it.step_length == 0)
            r = '0;
        else
        begin
            r.deposit = scored_deposit(running_sum, it);
            r.counted = 1'b1;
        end
        running_sum = '0;
        pending_deposits.insert(pending_deposits.size(), r);
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic tlde_item_t noise_item();
        tlde_item_t it;
        it = ITEM_BITS'({$urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    function automatic tlde_item_t load_item(int z, int idx, bit last, logic [31:0] e,
                                             logic [31:0] c);
        tlde_item_t it;
        it = noise_item();
        it.opcode        = OP_LOAD;
        it.atomic_number = 7'(z);
        it.point_index   = 6'(idx);
        it.point_last    = last;
        it.point_energy  = e;
        it.point_coeff   = c;
        return it;
    endfunction

    function automatic tlde_item_t term_item(int z, logic [15:0] wf, bit last,
                                             logic [31:0] ke, logic [31:0] len,
                                             logic [31:0] wt, logic [47:0] vol);
        tlde_item_t it;
        it = noise_item();
        it.opcode          = OP_TERM;
        it.atomic_number   = 7'(z);
        it.weight_fraction = wf;
        it.last_element    = last;
        it.kinetic_energy  = ke;
        it.step_length     = len;
        it.track_weight    = wt;
        it.cell_volume     = vol;
        return it;
    endfunction

    // one transfer on the input side; valid is only lowered when an idle cycle is chosen
    task automatic send_item(tlde_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        apply_item(it);
        items_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_deposits.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_row(int z, int n, bit sorted);
        logic [31:0] e;
        logic [31:0] c;
        logic [31:0] span;
        longint unsigned top;
        top = 64'hFFFF_FFFF;
        e = $urandom_range(1, 5000);
        span = ($urandom_range(1) == 0) ? 32'd100000 : (32'hFFFF_FFF0 / n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:       c = 32'd0;
                1:       c = $urandom_range(1, 255);
                2:       c = 32'hFFFF_FFFF;
                default: c = $urandom;
            endcase
            send_item(load_item(z, i, i == n - 1, sorted ? e : $urandom, c));
            if (top - e > span)
                e = e + $urandom_range(1, span);
            else if (e != 32'hFFFF_FFFF)
                e = e + 1;
        end
    endtask

    function automatic logic [31:0] pick_energy(int z);
        int unsigned n;
        logic [31:0] lo_e, hi_e;
        n = row_points[z];
        if (n == 0 || $urandom_range(9) == 0)
            return $urandom;
        lo_e = energy_rows[z*NPTS];
        hi_e = energy_rows[z*NPTS+n-1];
        if ($urandom_range(9) == 0)
            return energy_rows[z*NPTS + $urandom_range(n-1)];
        if (lo_e < hi_e)
            return $urandom_range(lo_e, hi_e);
        return lo_e;
    endfunction

    task automatic send_material(int rows);
        int z;
        logic [31:0] len, wt;
        logic [47:0] vol;
        len = ($urandom_range(9) == 0) ? 32'd0
            : ($urandom_range(1) ? $urandom_range(1, 1000) : $urandom);
        wt  = $urandom_range(1) ? 32'h0001_0000 : $urandom;
        case ($urandom_range(9))
            0:       vol = '0;
            1:       vol = 48'($urandom_range(1, 100));
            default: vol = 48'({$urandom, $urandom});
        endcase
        for (int k = 0; k < rows; k++)
        begin
            z = ($urandom_range(7) == 0) ? $urandom_range(NROWS-1) : $urandom_range(7);
            send_item(term_item(z, 16'($urandom), k == rows - 1, pick_energy(z), len, wt,
                                vol));
        end
    endtask

    // noise: any fields, but a point count never reaches over an unloaded entry
    task automatic send_noise();
        tlde_item_t it;
        int z;
        it = noise_item();
        z  = int'(it.atomic_number);
        if (it.opcode == OP_LOAD && it.point_last)
            for (int i = 0; i < it.point_index; i++)
                if (!row_loaded[z][i])
                    it.point_last = 1'b0;
        send_item(it);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        // ascending row with a zero coefficient for the lin-log bins
        send_item(load_item(3, 0, 0, 32'd1000, 32'h0002_0000));
        send_item(load_item(3, 1, 0, 32'd5000, 32'h0000_8000));
        send_item(load_item(3, 2, 0, 32'd20000, 32'd0));
        send_item(load_item(3, 3, 1, 32'd1000000, 32'h0010_0000));
        // unsorted row
        send_item(load_item(4, 0, 0, 32'd100, 32'h0001_0000));
        send_item(load_item(4, 1, 0, 32'd50000, 32'h0003_0000));
        send_item(load_item(4, 2, 0, 32'd2000, 32'h0005_0000));
        send_item(load_item(4, 3, 1, 32'd90000, 32'h0007_0000));
        // empty row, below the table, on the first point
        send_item(term_item(9, 16'hFFFF, 1, 32'd3000, 32'd10, 32'h0001_0000, 48'd1));
        send_item(term_item(3, 16'hFFFF, 1, 32'd500, 32'd10, 32'h0001_0000, 48'd1));
        send_item(term_item(3, 16'hFFFF, 1, 32'd1000, 32'd10, 32'h0001_0000, 48'd7));
        // log-log bin, lin-log bins, at and above the last point
        send_item(term_item(3, 16'h8000, 1, 32'd3000, 32'd1, 32'h0001_0000, 48'd3));
        send_item(term_item(3, 16'hFFFF, 1, 32'd10000, 32'd5, 32'h0002_0000, 48'd9));
        send_item(term_item(3, 16'hFFFF, 1, 32'd500000, 32'd5, 32'h0002_0000, 48'd9));
        send_item(term_item(3, 16'h4000, 1, 32'd1000000, 32'd2, 32'h0001_0000, 48'd5));
        send_item(term_item(3, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            48'hFFFF_FFFF_FFFF));
        // unsorted search, multi-element sum, zero step, zero volume, weight zero
        send_item(term_item(4, 16'h1234, 0, 32'd60000, 32'd3, 32'h0001_0000, 48'd1));
        send_item(term_item(3, 16'hFFFF, 0, 32'd3000, 32'd3, 32'h0001_0000, 48'd1));
        send_item(term_item(4, 16'h0000, 1, 32'd3000, 32'd3, 32'h0001_0000, 48'd1000));
        send_item(term_item(3, 16'hFFFF, 1, 32'd3000, 32'd0, 32'hFFFF_FFFF, 48'd1));
        send_item(term_item(3, 16'hFFFF, 1, 32'd3000, 32'd7, 32'h0001_0000, 48'd0));
        send_item(term_item(3, 16'h0001, 1, 32'd0, 32'd1, 32'd0, 48'd1));
        drain();
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        int stop_at;
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(19))
                0:       load_row($urandom_range(7), ($urandom_range(7) == 0) ? NPTS
                                  : $urandom_range(2, 8), $urandom_range(9) != 0);
                1, 2:    send_noise();
                default: send_material($urandom_range(1, 4));
            endcase
        end
        drain();
    endtask

    task automatic test_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        holdoff_armed     = 1'b1;
        for (int i = 0; i < 6; i++)
            send_material(1);
        drain();
    endtask

    // ---------------- receiver, checker, watchdog ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall   <= 1'b0;
            holdoff_cycles <= 0;
            holdoff_done   <= 1'b0;
        end
        else if (holdoff_armed && !holdoff_done)
        begin
            holdoff_cycles <= holdoff_cycles + 1;
            holdoff_done   <= (holdoff_cycles == HOLDOFF_LEN - 1);
            result_stall   <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        tlde_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_deposits.size() == 0)
                report_mismatch("unexpected result", result.deposit, '0);
            else
            begin
                want = pending_deposits.pop_front();
                if (result.deposit !== want.deposit)
                    report_mismatch("deposit", result.deposit, want.deposit);
                if (result.counted !== want.counted)
                    report_mismatch("counted", 64'(result.counted), 64'(want.counted));
                deposits_seen++;
                if (want.deposit == '1)
                    saturated_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        items_sent        = 0;
        loads_sent        = 0;
        running_sum       = '0;
        for (int z = 0; z < NROWS; z++)
        begin
            row_points[z] = 0;
            row_loaded[z] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(420, 35, 53);
        test_random(420, 53, 35);
        test_random(420, 0, 0);
        test_backpressure();

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d items (%0d table loads), %0d deposits checked, %0d saturated.",
                 items_sent, loads_sent, deposits_seen, saturated_seen);
        $display("Idle mixes, long output hold-off, empty/unsorted rows, zero step and volume.");
        if (mismatches == 0 && pending_deposits.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- track_length_dose_estimator_unit.f -----
+incdir+sv
sv/tlde_pkg.sv
sv/tlde_ram.sv
sv/tlde_div.sv
sv/track_length_dose_estimator_unit.sv
sv/tlde_checker.sv
verif/track_length_dose_estimator_unit_tb.sv
